// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL of the box blur block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BBL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bbl_pkg.sv -----
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants of the line box blur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbl_pkg;

  localparam int unsigned DEF_MAX_RADIUS = 31;
  localparam int unsigned NUM_LANES      = 4;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned PIX_W          = NUM_LANES * CHAN_W;
  localparam int unsigned CFG_RADIUS_W   = 5;
  localparam logic [CFG_RADIUS_W-1:0] CFG_RADIUS_RST = CFG_RADIUS_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_MUL,
    ST_EMIT
  } bbl_state_e;

  // Per-lane strobes from the sequencer.
  typedef struct packed {
    logic init;   // load window sum from the first pixel
    logic upd;    // slide window: add newest, drop oldest
    logic mul;    // multiply sum by window reciprocal
  } bbl_lane_ctl_t;

  // Result hand-off to the merging stage.
  typedef struct packed {
    logic valid;
    logic last;
  } bbl_emit_t;

endpackage

`default_nettype wire

// ----- rtl/bbl_lane.sv -----
// ----------------------------------------------------------------------------
// bbl_lane
// One channel: running window sum and truncated mean via reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbl_lane #(
  parameter int unsigned MAX_RADIUS = bbl_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                                 clk_i,
  input  wire bbl_pkg::bbl_lane_ctl_t               ctl_i,
  input  wire logic [bbl_pkg::CHAN_W-1:0]           add_i,
  input  wire logic [bbl_pkg::CHAN_W-1:0]           rem_i,
  input  wire logic [$clog2(MAX_RADIUS+1)-1:0]      radius_i,
  input  wire logic [$clog2((2*MAX_RADIUS+1)*((1 << bbl_pkg::CHAN_W)-1)+1)
                     + $clog2(2*MAX_RADIUS+2):0]    recip_i,
  output logic [bbl_pkg::CHAN_W-1:0]                quot_o
);

  localparam int unsigned RADW  = $clog2(MAX_RADIUS+1);
  localparam int unsigned SW    = $clog2((2*MAX_RADIUS+1)*((1 << bbl_pkg::CHAN_W)-1)+1);
  localparam int unsigned SHIFT = SW + $clog2(2*MAX_RADIUS+2);
  localparam int unsigned RW    = SHIFT + 1;
  localparam int unsigned IW    = RADW + bbl_pkg::CHAN_W;

  logic [SW-1:0]    sum_q, sum_d;
  logic [SW+RW-1:0] prod_q;
  logic [IW-1:0]    r_times_p;
  logic [IW+1:0]    init_sum;

  // First pixel fills the whole window: (2r+1) * p.
  assign r_times_p = IW'(radius_i) * IW'(add_i);
  assign init_sum  = {1'b0, r_times_p, 1'b0} + (IW+2)'(add_i);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.init) begin
      sum_d = SW'(init_sum);
    end else if (ctl_i.upd) begin
      sum_d = sum_q + SW'(add_i) - SW'(rem_i);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (ctl_i.mul) begin
      prod_q <= (SW+RW)'(sum_q) * (SW+RW)'(recip_i);
    end
  end

  assign quot_o = prod_q[SHIFT +: bbl_pkg::CHAN_W];

endmodule

`default_nettype wire

// ----- rtl/bbl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbl_ctrl
// Sequencer: pixel history, line tracking, window steps and edge clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbl_ctrl #(
  parameter int unsigned MAX_RADIUS = bbl_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_wr_en_i,
  input  wire logic [bbl_pkg::CFG_RADIUS_W-1:0]     cfg_wr_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [bbl_pkg::PIX_W-1:0]            in_px_i,
  input  wire logic                                 in_end_i,
  input  wire logic                                 out_free_i,
  output bbl_pkg::bbl_lane_ctl_t                    lane_ctl_o,
  output logic [bbl_pkg::PIX_W-1:0]                 add_px_o,
  output logic [bbl_pkg::PIX_W-1:0]                 rem_px_o,
  output logic [$clog2(MAX_RADIUS+1)-1:0]           radius_o,
  output logic [$clog2((2*MAX_RADIUS+1)*((1 << bbl_pkg::CHAN_W)-1)+1)
                + $clog2(2*MAX_RADIUS+2):0]         recip_o,
  output bbl_pkg::bbl_emit_t                        emit_o
);

  localparam int unsigned RADW  = $clog2(MAX_RADIUS+1);
  localparam int unsigned AW    = RADW + 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SW    = $clog2((2*MAX_RADIUS+1)*((1 << bbl_pkg::CHAN_W)-1)+1);
  localparam int unsigned SHIFT = SW + $clog2(2*MAX_RADIUS+2);
  localparam int unsigned RW    = SHIFT + 1;

  bbl_pkg::bbl_state_e state_q, state_d;

  logic [bbl_pkg::CFG_RADIUS_W-1:0] radius_q;
  logic [RADW-1:0]                  lag_q, step_q, r_new;
  logic [AW-1:0]                    cnt_q, wp_q, cur_k_q, cur_wp_q;
  logic [AW-1:0]                    rd_base, rd_back, rd_addr, cur_back;
  logic [RADW-1:0]                  rd_step;
  logic [bbl_pkg::PIX_W-1:0]        first_q, px_q, rd_q;
  logic [RW-1:0]                    recip_q;
  logic                             end_q, emit_q, last_q;
  logic                             accept, advance, more_steps;
  logic [AW:0]                      centre_chk;

  logic [bbl_pkg::PIX_W-1:0] hist_mem [DEPTH];
  logic [RW-1:0]             recip_tab [MAX_RADIUS+1];

  // Reciprocal ceil(2^SHIFT / (2r+1)) for every radius; exact for all sums.
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
    localparam logic [RW-1:0] RecipG =
      RW'(((64'd1 << SHIFT) + 64'(2*g)) / 64'(2*g+1));
    assign recip_tab[g] = RecipG;
  end

  assign accept = in_valid_i && in_ready_o;
  assign r_new  = (32'(radius_q) > 32'(MAX_RADIUS)) ? RADW'(MAX_RADIUS) : RADW'(radius_q);

  // Oldest pixel of the window: 2r+1 back from the newest, one less per flush step.
  assign rd_base  = (state_q == bbl_pkg::ST_IDLE) ? wp_q : cur_wp_q;
  assign rd_step  = (state_q == bbl_pkg::ST_IDLE) ? '0 : step_q;
  assign rd_back  = {lag_q, 1'b1} - AW'(rd_step);
  assign rd_addr  = rd_base - rd_back;
  assign cur_back = {lag_q, 1'b1} - AW'(step_q);

  assign centre_chk = {1'b0, cur_k_q} + (AW+1)'(step_q);
  assign more_steps = end_q && (step_q != lag_q);
  assign advance    = !emit_q || out_free_i;

  // History ring: one write per accepted pixel and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_mem[wp_q] <= in_px_i;
    end
    rd_q <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    lane_ctl_o = '0;
    emit_o     = '0;
    unique case (state_q)
      bbl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = bbl_pkg::ST_UPD;
        end
      end
      bbl_pkg::ST_READ: begin
        state_d = bbl_pkg::ST_UPD;
      end
      bbl_pkg::ST_UPD: begin
        lane_ctl_o.init = (cur_k_q == '0) && (step_q == '0);
        lane_ctl_o.upd  = !lane_ctl_o.init;
        state_d         = bbl_pkg::ST_MUL;
      end
      bbl_pkg::ST_MUL: begin
        lane_ctl_o.mul = 1'b1;
        state_d        = bbl_pkg::ST_EMIT;
      end
      bbl_pkg::ST_EMIT: begin
        emit_o.valid = emit_q && out_free_i;
        emit_o.last  = last_q;
        if (advance) begin
          state_d = more_steps ? bbl_pkg::ST_READ : bbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbl_pkg::ST_IDLE;
      end
    endcase
  end

  // Line tracking and per-step flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= bbl_pkg::CFG_RADIUS_RST;
      lag_q    <= '0;
      first_q  <= '0;
      cnt_q    <= '0;
      wp_q     <= '0;
      step_q   <= '0;
      end_q    <= 1'b0;
      emit_q   <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        radius_q <= cfg_wr_data_i;
      end
      if (accept) begin
        end_q  <= in_end_i;
        step_q <= '0;
        wp_q   <= wp_q + AW'(1);
        if (cnt_q == '0) begin
          lag_q   <= r_new;
          first_q <= in_px_i;
        end
        if (in_end_i) begin
          cnt_q <= '0;
        end else if (cnt_q != '1) begin
          cnt_q <= cnt_q + AW'(1);
        end
      end
      if (state_q == bbl_pkg::ST_UPD) begin
        // Emit once the window centre lies inside the line.
        emit_q <= centre_chk >= (AW+1)'(lag_q);
        last_q <= end_q && (step_q == lag_q);
      end
      if (state_q == bbl_pkg::ST_EMIT && advance && more_steps) begin
        step_q <= step_q + RADW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q     <= in_px_i;
      cur_k_q  <= cnt_q;
      cur_wp_q <= wp_q;
      if (cnt_q == '0) begin
        recip_q <= recip_tab[r_new];
      end
    end
  end

  // Before the line start, repeat the first pixel.
  assign rem_px_o = (cur_back > cur_k_q) ? first_q : rd_q;
  assign add_px_o = px_q;
  assign radius_o = lag_q;
  assign recip_o  = recip_q;

endmodule

`default_nettype wire

// ----- rtl/box_blur_line_clamped.sv -----
// ----------------------------------------------------------------------------
// box_blur_line_clamped
// One-dimensional edge-clamped box blur over a line of four-channel pixels.
// ----------------------------------------------------------------------------
// Flow: each pixel steps through the sum, multiply and emit states; emit loads
//   the output register once the window centre lies in the line. The end pixel
//   then releases up to r more results by flush steps of read, sum, multiply and
//   emit. A new pixel is taken only in idle; emit waits while m_axis is not free.
// Reset: asynchronous, active low; clears the line position, sets radius to 1.
//   The pixel history needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module box_blur_line_clamped #(
  parameter int unsigned MAX_RADIUS = bbl_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration: blur_radius
  input  wire logic                             cfg_wr_en_i,
  input  wire logic [bbl_pkg::CFG_RADIUS_W-1:0] cfg_wr_data_i,
  // Pixel input
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bbl_pkg::PIX_W-1:0]        s_axis_tdata,  // chan_a, chan_b, chan_c, chan_d
  input  wire logic                             s_axis_tlast,  // line_end
  // Blurred output
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [bbl_pkg::PIX_W-1:0]             m_axis_tdata,  // out_a, out_b, out_c, out_d
  output logic                                  m_axis_tlast   // out_line_last
);

  localparam int unsigned RADW  = $clog2(MAX_RADIUS+1);
  localparam int unsigned SW    = $clog2((2*MAX_RADIUS+1)*((1 << bbl_pkg::CHAN_W)-1)+1);
  localparam int unsigned RW    = SW + $clog2(2*MAX_RADIUS+2) + 1;

  bbl_pkg::bbl_lane_ctl_t    lane_ctl;
  bbl_pkg::bbl_emit_t        emit;
  logic [bbl_pkg::PIX_W-1:0] add_px, rem_px, quot;
  logic [RADW-1:0]           radius;
  logic [RW-1:0]             recip;
  logic                      out_free;

  logic                      out_valid_q;
  logic [bbl_pkg::PIX_W-1:0] out_data_q;
  logic                      out_last_q;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  bbl_ctrl #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_px_i      (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .out_free_i   (out_free),
    .lane_ctl_o   (lane_ctl),
    .add_px_o     (add_px),
    .rem_px_o     (rem_px),
    .radius_o     (radius),
    .recip_o      (recip),
    .emit_o       (emit)
  );

  // One lane per channel byte; all lanes step together.
  for (genvar l = 0; l < bbl_pkg::NUM_LANES; l++) begin : g_lane
    bbl_lane #(
      .MAX_RADIUS(MAX_RADIUS)
    ) u_lane (
      .clk_i   (clk_i),
      .ctl_i   (lane_ctl),
      .add_i   (add_px[l*bbl_pkg::CHAN_W +: bbl_pkg::CHAN_W]),
      .rem_i   (rem_px[l*bbl_pkg::CHAN_W +: bbl_pkg::CHAN_W]),
      .radius_i(radius),
      .recip_i (recip),
      .quot_o  (quot[l*bbl_pkg::CHAN_W +: bbl_pkg::CHAN_W])
    );
  end

  // Merge the lane means into one output pixel; hold until transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_data_q <= quot;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Never overwrite a result that has not been transferred.
  `BBL_ASSERT_IMP(a_emit_free, clk_i, rst_ni, emit.valid, out_free, "result overwrite")
  // Results are only produced while no new pixel can be taken.
  `BBL_ASSERT_IMP(a_emit_busy, clk_i, rst_ni, emit.valid, !s_axis_tready, "emit while idle")
  // A pixel transfer always drops ready for the step that it starts.
  `BBL_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   !s_axis_tready, "ready after transfer")

endmodule

`default_nettype wire
